/* rtl/rbof_pkg.sv */
// Shared types and constants of the overwriting ring buffer FIFO.
package rbof_pkg;

   // Default number of words the buffer holds.
   localparam int unsigned RBOF_DEPTH = 128;

   // Operation carried by an input beat.
   typedef enum logic [1:0] {
      MODE_APPEND = 2'd0,
      MODE_TAKE   = 2'd1,
      MODE_DROP   = 2'd2,
      MODE_PEEK   = 2'd3
   } mode_type;

   // Status reported with every result beat.
   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_DISCARD   = 2'd2,
      ST_OVERWRITE = 2'd3
   } status_type;

   // Result information that the control hands to the output stages.
   typedef struct packed {
      logic       use_rdata;
      status_type status;
      logic [7:0] fill;
   } info_type;

endpackage

/* rtl/rbof_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
module rbof_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   // Read port; the data holds until the next enabled read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/rbof_ctrl.sv */
// Pointer and fill control that turns each operation into at most one RAM access.
module rbof_ctrl #(
   parameter int unsigned DEPTH = rbof_pkg::RBOF_DEPTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  logic [1:0]               mode,
   input  logic [31:0]              write_word,
   input  logic                     drop_when_full,
   input  logic [7:0]               drop_count,
   input  logic [7:0]               peek_index,
   output logic                     ram_wr_en,
   output logic [$clog2(DEPTH)-1:0] ram_wr_addr,
   output logic [31:0]              ram_wr_data,
   output logic                     ram_rd_en,
   output logic [$clog2(DEPTH)-1:0] ram_rd_addr,
   output rbof_pkg::info_type       info
);
   import rbof_pkg::*;

   localparam int unsigned AW = $clog2(DEPTH);
   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam int unsigned XW = (CW > 8) ? CW : 8;
   localparam int unsigned SW = CW + 1;

   // Circular add; the offset never exceeds DEPTH, so one subtract wraps it.
   function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                              input logic [CW-1:0] offset);
      logic [SW-1:0] sum;
      sum = SW'(base) + SW'(offset);
      if (sum >= SW'(DEPTH)) begin
         sum = sum - SW'(DEPTH);
      end
      return sum[AW-1:0];
   endfunction

   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CW-1:0] held_ff, held_in;
   logic          full;
   logic          empty;
   logic [CW-1:0] drop_n;
   logic [CW-1:0] last;
   logic [CW-1:0] pos;

   assign full  = (held_ff == CW'(DEPTH));
   assign empty = (held_ff == '0);
   assign last  = held_ff - CW'(1);

   // Clamp the drop count to the fill and the peek position to the newest word.
   assign drop_n = (XW'(drop_count) > XW'(held_ff)) ? held_ff : CW'(drop_count);
   assign pos    = (XW'(peek_index) > XW'(last)) ? last : CW'(peek_index);

   // Next pointers, RAM access and result status of the offered operation.
   always_comb begin
      rd_ptr_in      = rd_ptr_ff;
      wr_ptr_in      = wr_ptr_ff;
      held_in        = held_ff;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = wr_ptr_ff;
      ram_wr_data    = write_word;
      ram_rd_en      = 1'b0;
      ram_rd_addr    = rd_ptr_ff;
      info.use_rdata = 1'b0;
      info.status    = ST_OK;
      unique case (mode_type'(mode))
         MODE_APPEND: begin
            if (full) begin
               if (drop_when_full) begin
                  info.status = ST_DISCARD;
               end else begin
                  ram_wr_en   = accept;
                  wr_ptr_in   = ring_add(wr_ptr_ff, CW'(1));
                  rd_ptr_in   = ring_add(rd_ptr_ff, CW'(1));
                  info.status = ST_OVERWRITE;
               end
            end else begin
               ram_wr_en = accept;
               wr_ptr_in = ring_add(wr_ptr_ff, CW'(1));
               held_in   = held_ff + CW'(1);
            end
         end
         MODE_TAKE: begin
            if (empty) begin
               info.status = ST_EMPTY;
            end else begin
               ram_rd_en      = accept;
               info.use_rdata = 1'b1;
               rd_ptr_in      = ring_add(rd_ptr_ff, CW'(1));
               held_in        = held_ff - CW'(1);
            end
         end
         MODE_DROP: begin
            rd_ptr_in = ring_add(rd_ptr_ff, drop_n);
            held_in   = held_ff - drop_n;
         end
         MODE_PEEK: begin
            if (empty) begin
               info.status = ST_EMPTY;
            end else begin
               ram_rd_en      = accept;
               ram_rd_addr    = ring_add(rd_ptr_ff, pos);
               info.use_rdata = 1'b1;
            end
         end
      endcase
      // The reported fill is the low byte of the count after the operation.
      info.fill = 8'(held_in);
   end

   // Commit the pointers on every accepted beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         held_ff   <= '0;
      end else if (accept) begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         held_ff   <= held_in;
      end
   end

endmodule

/* rtl/ring_buffer_overwrite_fifo.sv */
// Top level of the overwriting ring buffer FIFO of 32-bit words.
//
//   Channel   Direction   Handshake               Fields
//   req       in          req_valid / req_ready   mode, write_word, drop_when_full,
//                                                 drop_count, peek_index
//   rsp       out         rsp_valid / rsp_ready   read_word, fill_level, status
//
// One beat is accepted per cycle while the response is not stalled; its result
// passes through the read stage and then the response register.
// The pointer update and the RAM access, if any, both happen at the accepting edge;
// the registered RAM read and the response register set the delay, not the rate.
// A stalled response holds the read stage, and req_ready drops until it moves.
// Synchronous reset empties the buffer; the RAM contents are not cleared.
module ring_buffer_overwrite_fifo #(
   parameter int unsigned DEPTH = rbof_pkg::RBOF_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_mode,
   input  logic [31:0] req_write_word,
   input  logic        req_drop_when_full,
   input  logic [7:0]  req_drop_count,
   input  logic [7:0]  req_peek_index,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_read_word,
   output logic [7:0]  rsp_fill_level,
   output logic [1:0]  rsp_status
);
   import rbof_pkg::*;

   localparam int unsigned AW = $clog2(DEPTH);

   logic          accept;
   logic          advance;
   logic          ram_wr_en;
   logic [AW-1:0] ram_wr_addr;
   logic [31:0]   ram_wr_data;
   logic          ram_rd_en;
   logic [AW-1:0] ram_rd_addr;
   logic [31:0]   ram_rd_data;
   info_type      info;

   logic          s1_valid_ff, s1_valid_in;
   info_type      s1_info_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [31:0]   rsp_word_ff;
   logic [7:0]    rsp_fill_ff;
   logic [1:0]    rsp_status_ff;

   rbof_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .mode           (req_mode),
      .write_word     (req_write_word),
      .drop_when_full (req_drop_when_full),
      .drop_count     (req_drop_count),
      .peek_index     (req_peek_index),
      .ram_wr_en      (ram_wr_en),
      .ram_wr_addr    (ram_wr_addr),
      .ram_wr_data    (ram_wr_data),
      .ram_rd_en      (ram_rd_en),
      .ram_rd_addr    (ram_rd_addr),
      .info           (info)
   );

   rbof_ram #(
      .WIDTH (32),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Handshake: the read stage moves when the response register is free or being taken.
   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   assign accept    = req_valid && req_ready;

   assign s1_valid_in  = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   // Valid bits of the read stage and the response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Read stage: result information waits here for the RAM data.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_info_ff <= info;
      end
   end

   // Response register: the read word is zero unless a word was taken or peeked.
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_word_ff   <= s1_info_ff.use_rdata ? ram_rd_data : 32'd0;
         rsp_fill_ff   <= s1_info_ff.fill;
         rsp_status_ff <= s1_info_ff.status;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_word  = rsp_word_ff;
   assign rsp_fill_level = rsp_fill_ff;
   assign rsp_status     = rsp_status_ff;

endmodule

/* rtl/rbof_checker.sv */
// Port-level checks of the ring buffer FIFO and the bind that attaches them.
module rbof_checker #(
   parameter int unsigned DEPTH = rbof_pkg::RBOF_DEPTH
) (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_read_word,
   input logic [7:0]  rsp_fill_level,
   input logic [1:0]  rsp_status
);
   import rbof_pkg::*;

   localparam logic [7:0] FULL_FILL = 8'(DEPTH);

   // Nothing is offered and a request can be taken in the cycle after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid && req_ready)
      else $error("response valid or request not ready right after reset");

   // A stalled response beat holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_read_word) && $stable(rsp_fill_level)
         && $stable(rsp_status))
      else $error("stalled response beat changed");

   // An empty error reports an empty buffer and no data.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_EMPTY) |->
         (rsp_read_word == 32'd0) && (rsp_fill_level == 8'd0))
      else $error("empty error with data or nonzero fill");

   // Discard and overwrite happen only on a full buffer, which stays full.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_status == ST_DISCARD) || (rsp_status == ST_OVERWRITE)) |->
         (rsp_read_word == 32'd0) && (rsp_fill_level == FULL_FILL))
      else $error("full-buffer append reported wrong fill or data");

endmodule

bind ring_buffer_overwrite_fifo rbof_checker #(
   .DEPTH (DEPTH)
) u_rbof_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_read_word  (rsp_read_word),
   .rsp_fill_level (rsp_fill_level),
   .rsp_status     (rsp_status)
);
